// ===== rtl/dwmd_pkg.sv =====
// Shared types and constants for the distinct window marker detector.
// No dependencies; imported by dwmd_history, dwmd_fifo and the core module.
`timescale 1ns / 1ps

package dwmd_pkg;

  localparam int BYTE_W             = 8;
  localparam int BYTE_VALUES        = 256;
  localparam int WLEN_W             = 5;
  localparam int POSITION_WIDTH     = 24;
  localparam int MAX_WINDOW_DEFAULT = 16;
  localparam logic [WLEN_W-1:0] WINDOW_RESET = 5'd4;

  localparam int OUT_FIFO_DEPTH = 4;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_WINDOW_LENGTH = '0;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic                      found;
    logic [POSITION_WIDTH-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] data_byte;
  } hist_wr_t;

endpackage

// ===== rtl/dwmd_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dwmd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  output logic [WIDTH-1:0]  rdata_a_o,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [WIDTH-1:0]  rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/dwmd_history.sv =====
// Last-seen index table per byte value: RAM plus valid flags and an aging sweep.
// Depends on dwmd_pkg and dwmd_ram.
`timescale 1ns / 1ps

module dwmd_history #(
  parameter int MAX_WINDOW = dwmd_pkg::MAX_WINDOW_DEFAULT,
  parameter int IDX_W      = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dwmd_pkg::BYTE_W-1:0] rd_byte_i,
  input  dwmd_pkg::hist_wr_t          wr_i,
  input  logic [IDX_W-1:0]            cur_idx_i,
  output logic                        seen_o,
  output logic [IDX_W-1:0]            last_idx_o
);

  import dwmd_pkg::*;

  logic [BYTE_VALUES-1:0] valid_q, valid_d;
  logic [BYTE_W-1:0]      rd_byte_q;
  logic [BYTE_W-1:0]      sweep_q;
  logic [BYTE_W-1:0]      sweep_addr_q;
  logic                   sweep_hit_q;
  logic [IDX_W-1:0]       sweep_data;
  logic [IDX_W-1:0]       sweep_age;
  logic                   sweep_clr;

  dwmd_ram #(
    .WIDTH (IDX_W),
    .DEPTH (BYTE_VALUES)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr_i.en),
    .waddr_i   (wr_i.data_byte),
    .wdata_i   (cur_idx_i),
    .raddr_a_i (rd_byte_i),
    .rdata_a_o (last_idx_o),
    .raddr_b_i (sweep_q),
    .rdata_b_o (sweep_data)
  );

  // entries older than the largest window can never match; dropping them keeps
  // every live entry well inside the index wrap
  assign sweep_age = cur_idx_i - sweep_data;
  assign sweep_clr = !sweep_hit_q && (sweep_age > IDX_W'(MAX_WINDOW));
  assign seen_o    = valid_q[rd_byte_q];

  // a write in the same cycle wins over the sweep clear
  always_comb begin
    valid_d = valid_q;
    if (sweep_clr) begin
      valid_d[sweep_addr_q] = 1'b0;
    end
    if (wr_i.en) begin
      valid_d[wr_i.data_byte] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      sweep_q      <= '0;
      sweep_addr_q <= '0;
      sweep_hit_q  <= 1'b0;
      rd_byte_q    <= '0;
    end else begin
      sweep_q      <= sweep_q + 1'b1;
      sweep_addr_q <= sweep_q;
      sweep_hit_q  <= wr_i.en && (wr_i.data_byte == sweep_q);
      rd_byte_q    <= rd_byte_i;
      valid_q      <= valid_d;
    end
  end

endmodule

// ===== rtl/dwmd_fifo.sv =====
// Small result queue between the detector stage and the output channel.
// Depends on dwmd_pkg.
`timescale 1ns / 1ps

module dwmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dwmd_pkg::out_item_t push_item_i,
  input  logic                pop_i,
  output logic                valid_o,
  output dwmd_pkg::out_item_t item_o,
  output logic [$clog2(dwmd_pkg::OUT_FIFO_DEPTH+1)-1:0] count_o
);

  import dwmd_pkg::*;

  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  out_item_t        mem_q [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/distinct_window_marker_detector_core.sv =====
// Top level of the distinct window marker detector: config register, detect stage.
// Depends on dwmd_pkg, dwmd_history, dwmd_fifo.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o  | in_item_i  (data_byte, end_of_stream)
//   out     | output    | out_valid_o / out_stall_i| out_item_o (found, position)
//   cfg     | input     | APB psel/penable/pready  | window_length at byte address 0
//
// One item per cycle while in_stall_o is low. The last-seen table read is registered
// alongside the item into the detect stage, which pushes at most one result per stream.
// Reset clears the valid flags of the table at once; no clearing pass is needed.
// in_stall_o rises when the result queue and the detect stage could overflow the
// four-entry queue; it depends only on registered state.
`timescale 1ns / 1ps

module distinct_window_marker_detector_core #(
  parameter int MAX_WINDOW = dwmd_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  dwmd_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dwmd_pkg::out_item_t             out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dwmd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dwmd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dwmd_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  import dwmd_pkg::*;

  localparam int RUN_W = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W = (RUN_W > WLEN_W) ? RUN_W : WLEN_W;
  localparam int IDX_W = $clog2(MAX_WINDOW + BYTE_VALUES) + 2;
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  logic [WLEN_W-1:0]         window_length_q;
  logic                      reg_sel;
  logic                      cfg_write;

  logic                      s1_valid_q;
  logic                      s1_last_q;
  logic [BYTE_W-1:0]         s1_byte_q;
  logic                      s1_fwd_q;

  logic [RUN_W-1:0]          run_q, run_d;
  logic [POSITION_WIDTH-1:0] count_q, count_d;
  logic                      marker_q, marker_d;
  logic [IDX_W-1:0]          gidx_q;

  logic                      accept;
  logic                      seen;
  logic [IDX_W-1:0]          last_idx;
  hist_wr_t                  hist_wr;

  logic [IDX_W-1:0]          copy_gap;
  logic                      copy_hit;
  logic [RUN_W:0]            run_inc;
  logic [RUN_W-1:0]          run_new;
  logic [POSITION_WIDTH-1:0] count_new;
  logic [LEN_W-1:0]          wl_ext;
  logic [LEN_W-1:0]          eff_len;
  logic                      emit_found;
  logic                      emit_none;
  out_item_t                 push_item;
  logic [CNT_W-1:0]          fifo_cnt;
  logic [CNT_W:0]            pending;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[APB_ADDR_W-1:2] == REG_WINDOW_LENGTH);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = reg_sel ? APB_DATA_W'(window_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= WINDOW_RESET;
    end else if (cfg_write && reg_sel) begin
      window_length_q <= pwdata[WLEN_W-1:0];
    end
  end

  // input side
  assign pending    = (CNT_W + 1)'(fifo_cnt) + (CNT_W + 1)'(s1_valid_q);
  assign in_stall_o = pending >= (CNT_W + 1)'(OUT_FIFO_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  assign hist_wr.en        = s1_valid_q;
  assign hist_wr.data_byte = s1_byte_q;

  dwmd_history #(
    .MAX_WINDOW (MAX_WINDOW),
    .IDX_W      (IDX_W)
  ) u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_byte_i  (in_item_i.data_byte),
    .wr_i       (hist_wr),
    .cur_idx_i  (gidx_q),
    .seen_o     (seen),
    .last_idx_o (last_idx)
  );

  // detect stage; the previous item's table write is not yet visible to the read
  always_comb begin
    copy_gap  = s1_fwd_q ? IDX_W'(1) : (gidx_q - last_idx);
    copy_hit  = (s1_fwd_q || seen) && (copy_gap <= IDX_W'(run_q));
    run_inc   = {1'b0, run_q} + 1'b1;
    if (copy_hit) begin
      run_new = RUN_W'(copy_gap);
    end else if (run_inc > (RUN_W + 1)'(MAX_WINDOW)) begin
      run_new = RUN_W'(MAX_WINDOW);
    end else begin
      run_new = run_inc[RUN_W-1:0];
    end
    count_new = (count_q == '1) ? count_q : count_q + 1'b1;

    wl_ext = LEN_W'(window_length_q);
    if (wl_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (wl_ext > LEN_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = wl_ext;
    end

    emit_found = s1_valid_q && !marker_q && (LEN_W'(run_new) >= eff_len);
    emit_none  = s1_valid_q && s1_last_q && !marker_q && !emit_found;

    push_item.found    = emit_found;
    push_item.position = emit_found ? count_new : '0;

    run_d    = run_q;
    count_d  = count_q;
    marker_d = marker_q;
    if (s1_valid_q) begin
      if (s1_last_q) begin
        run_d    = '0;
        count_d  = '0;
        marker_d = 1'b0;
      end else begin
        run_d    = run_new;
        count_d  = count_new;
        marker_d = marker_q || emit_found;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= in_item_i.end_of_stream;
      s1_byte_q <= in_item_i.data_byte;
      s1_fwd_q  <= s1_valid_q && (s1_byte_q == in_item_i.data_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      run_q      <= '0;
      count_q    <= '0;
      marker_q   <= 1'b0;
      gidx_q     <= '0;
    end else begin
      s1_valid_q <= accept;
      run_q      <= run_d;
      count_q    <= count_d;
      marker_q   <= marker_d;
      if (s1_valid_q) begin
        gidx_q <= gidx_q + 1'b1;
      end
    end
  end

  dwmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (emit_found || emit_none),
    .push_item_i (push_item),
    .pop_i       (out_valid_o && !out_stall_i),
    .valid_o     (out_valid_o),
    .item_o      (out_item_o),
    .count_o     (fifo_cnt)
  );

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q <= RUN_W'(MAX_WINDOW))
    else $error("distinct run exceeds window limit");

  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_found || emit_none) |-> (push_item.found == (push_item.position != '0)))
    else $error("found flag and position disagree");

  a_stream_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |=> (run_q == '0 && count_q == '0 && !marker_q))
    else $error("stream state not cleared after last item");

  a_one_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    marker_q |-> !emit_found)
    else $error("second marker reported in one stream");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_found || emit_none) |-> (fifo_cnt < CNT_W'(OUT_FIFO_DEPTH)))
    else $error("result queue overflow");

endmodule
